// File: rtl/core/work_partition_coordinates_assert.svh
// Assertion macros for the work partition coordinates block.
// Used by the top level only; no other dependencies.
`ifndef WORK_PARTITION_COORDINATES_ASSERT_SVH
`define WORK_PARTITION_COORDINATES_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define WPC_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("wpc implication check failed");

// Next-cycle implication, also checked during reset.
`define WPC_ASSERT_NEXT(label, clk, cond, expr) \
    label: assert property (@(posedge clk) (cond) |=> (expr)) \
        else $error("wpc next-cycle check failed");

`endif

// File: rtl/core/wpc_pkg.sv
// Shared constants and helpers for the work partition coordinates block.
// No dependencies.
`default_nettype none
package wpc_pkg;
    localparam int MAX_DIMS    = 3;
    localparam int EXTENT_BITS = 12;
    localparam int WORKER_BITS = 6;

    localparam int EXT_W     = EXTENT_BITS + 1;
    localparam int COORD_W   = EXTENT_BITS;
    localparam int WK_W      = WORKER_BITS;
    localparam int WKC_W     = WORKER_BITS + 1;
    localparam int DIM_W     = 2;
    localparam int IDX_W     = 37;
    localparam int OIDX_W    = 36;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = EXT_W;

    localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(1) << EXTENT_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 3'd4;

    localparam logic [DIM_W-1:0] RST_DIM_COUNT    = 2'd3;
    localparam logic [EXT_W-1:0] RST_EXTENT       = 13'd4;
    localparam logic [WKC_W-1:0] RST_WORKER_COUNT = 7'd3;

    localparam int WDIV_STEPS = 8;
    localparam int EDIV_STEPS = 4;
    localparam int WDIV_LAT   = (IDX_W + WDIV_STEPS - 1) / WDIV_STEPS;
    localparam int EDIV_LAT   = (IDX_W + EDIV_STEPS - 1) / EDIV_STEPS;

    function automatic logic [EXT_W-1:0] eff_ext(input logic [EXT_W-1:0] e);
        logic [EXT_W-1:0] r;
        r = e;
        if (e == '0) r = EXT_W'(1);
        if (e > EXT_MAX) r = EXT_MAX;
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/wpc_div.sv
// Pipelined restoring divider, K quotient bits per stage, registered stages.
// Depends on nothing.
`default_nettype none
module wpc_div #(
    parameter int N = 37,
    parameter int D = 13,
    parameter int K = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [N-1:0] i_dividend,
    input  wire logic [D-1:0] i_divisor,
    output logic              o_valid,
    output logic [N-1:0]      o_quotient,
    output logic [D-1:0]      o_remainder
);
    localparam int S = (N + K - 1) / K;
    localparam int M = S * K;

    logic         r_vld [S];
    logic [D-1:0] r_rem [S];
    logic [M-1:0] r_wrk [S];
    logic [D-1:0] r_dvs [S];

    for (genvar s = 0; s < S; s++) begin : g_stage
        logic         s_vld;
        logic [D-1:0] s_rem;
        logic [M-1:0] s_wrk;
        logic [D-1:0] s_dvs;
        logic [D-1:0] n_rem;
        logic [M-1:0] n_wrk;

        if (s == 0) begin : g_first
            assign s_vld = i_valid;
            assign s_rem = '0;
            assign s_wrk = M'(i_dividend);
            assign s_dvs = i_divisor;
        end else begin : g_next
            assign s_vld = r_vld[s-1];
            assign s_rem = r_rem[s-1];
            assign s_wrk = r_wrk[s-1];
            assign s_dvs = r_dvs[s-1];
        end

        always_comb begin
            logic [D:0] t;
            logic       q;
            n_rem = s_rem;
            n_wrk = s_wrk;
            for (int k = 0; k < K; k++) begin
                t = {n_rem, n_wrk[M-1]};
                q = (t >= {1'b0, s_dvs});
                n_wrk = {n_wrk[M-2:0], q};
                if (q) begin
                    n_rem = D'(t - {1'b0, s_dvs});
                end else begin
                    n_rem = t[D-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_wrk[s] <= n_wrk;
            r_dvs[s] <= s_dvs;
        end
    end

    assign o_valid     = r_vld[S-1];
    assign o_quotient  = r_wrk[S-1][N-1:0];
    assign o_remainder = r_rem[S-1];
endmodule
`default_nettype wire

// File: rtl/core/wpc_delay.sv
// Fixed-length register delay line for side data of the pipeline.
// Depends on nothing.
`default_nettype none
module wpc_delay #(
    parameter int W = 8,
    parameter int L = 1
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_data,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_tap [L];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_data;
        for (int i = 1; i < L; i++) begin
            r_tap[i] <= r_tap[i-1];
        end
    end

    assign o_data = r_tap[L-1];
endmodule
`default_nettype wire

// File: rtl/core/work_partition_coordinates.sv
// Work partition coordinates: one worker query per cycle, in a pipeline of 3 setup stages,
// worker divider (5), 2 stages, two extent dividers (10 each) and an output register;
// throughput one query per clock, never stalls.
// Synchronous active-low reset restores the register defaults and empties the pipeline.
// Depends on wpc_pkg, wpc_div, wpc_delay and the assertion macro header.
`default_nettype none
`include "work_partition_coordinates_assert.svh"
module work_partition_coordinates (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [wpc_pkg::WK_W-1:0]         i_worker_id,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [wpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [wpc_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output logic                                  o_strobe,
    output logic                                  o_id_valid,
    output logic [wpc_pkg::OIDX_W-1:0]            o_first_index,
    output logic [wpc_pkg::OIDX_W-1:0]            o_last_index,
    output logic [wpc_pkg::IDX_W-1:0]             o_share_count,
    output logic [wpc_pkg::IDX_W-1:0]             o_rows_touched,
    output logic [wpc_pkg::COORD_W-1:0]           o_begin_coord_0,
    output logic [wpc_pkg::COORD_W-1:0]           o_begin_coord_1,
    output logic [wpc_pkg::COORD_W-1:0]           o_begin_coord_2,
    output logic [wpc_pkg::COORD_W-1:0]           o_end_coord_0,
    output logic [wpc_pkg::COORD_W-1:0]           o_end_coord_1,
    output logic [wpc_pkg::COORD_W-1:0]           o_end_coord_2
);
    import wpc_pkg::*;

    localparam int SX_W = 1 + WK_W + 4 * EXT_W;
    localparam int SY_W = 1 + IDX_W + 2 * OIDX_W + 2 * EXT_W;
    localparam int SZ_W = 1 + IDX_W + 2 * OIDX_W + 3 * EXT_W + IDX_W;

    logic [DIM_W-1:0] r_dim_count;
    logic [EXT_W-1:0] r_ext0, r_ext1, r_ext2;
    logic [WKC_W-1:0] r_worker_count;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count    <= RST_DIM_COUNT;
            r_ext0         <= RST_EXTENT;
            r_ext1         <= RST_EXTENT;
            r_ext2         <= RST_EXTENT;
            r_worker_count <= RST_WORKER_COUNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DIM_COUNT:    r_dim_count    <= i_cfg_data[DIM_W-1:0];
                CFG_EXTENT_0:     r_ext0         <= i_cfg_data;
                CFG_EXTENT_1:     r_ext1         <= i_cfg_data;
                CFG_EXTENT_2:     r_ext2         <= i_cfg_data;
                CFG_WORKER_COUNT: r_worker_count <= i_cfg_data[WKC_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: effective extents and range check
    logic             n1_use1, n1_use2;
    logic [EXT_W-1:0] n1_e0, n1_e1, n1_e2, n1_ein;
    logic             r1_vld, r1_ok;
    logic [WK_W-1:0]  r1_tid;
    logic [EXT_W-1:0] r1_e0, r1_e1, r1_e2, r1_ein;

    always_comb begin
        n1_use1 = r_dim_count[1];
        n1_use2 = (r_dim_count == 2'd3);
        n1_e0   = eff_ext(r_ext0);
        n1_e1   = n1_use1 ? eff_ext(r_ext1) : EXT_W'(1);
        n1_e2   = n1_use2 ? eff_ext(r_ext2) : EXT_W'(1);
        n1_ein  = n1_use2 ? n1_e2 : (n1_use1 ? n1_e1 : n1_e0);
    end

    // stage 2 and 3: total element count
    logic                 r2_vld, r2_ok;
    logic [WK_W-1:0]      r2_tid;
    logic [EXT_W-1:0]     r2_e0, r2_e1, r2_e2, r2_ein;
    logic [2*EXT_W-1:0]   r2_p12;
    logic                 r3_vld;
    logic [IDX_W-1:0]     r3_total;
    logic [SX_W-1:0]      r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_tid   <= i_worker_id;
        r1_ok    <= {1'b0, i_worker_id} < r_worker_count;
        r1_e0    <= n1_e0;
        r1_e1    <= n1_e1;
        r1_e2    <= n1_e2;
        r1_ein   <= n1_ein;
        r2_ok    <= r1_ok;
        r2_tid   <= r1_tid;
        r2_e0    <= r1_e0;
        r2_e1    <= r1_e1;
        r2_e2    <= r1_e2;
        r2_ein   <= r1_ein;
        r2_p12   <= (2*EXT_W)'(r1_e1) * (2*EXT_W)'(r1_e2);
        r3_total <= IDX_W'(r2_e0) * IDX_W'(r2_p12);
        r3_side  <= {r2_ok, r2_tid, r2_e0, r2_e1, r2_e2, r2_ein};
    end

    // worker divider: base share and spill
    logic             x_vld;
    logic [IDX_W-1:0] x_base;
    logic [WKC_W-1:0] x_spill;
    logic [SX_W-1:0]  x_side;
    logic             x_ok;
    logic [WK_W-1:0]  x_tid;
    logic [EXT_W-1:0] x_e0, x_e1, x_e2, x_ein;

    wpc_div #(.N(IDX_W), .D(WKC_W), .K(WDIV_STEPS)) u_wdiv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r3_vld),
        .i_dividend  (r3_total),
        .i_divisor   (r_worker_count),
        .o_valid     (x_vld),
        .o_quotient  (x_base),
        .o_remainder (x_spill)
    );

    wpc_delay #(.W(SX_W), .L(WDIV_LAT)) u_xdly (
        .i_clk  (i_clk),
        .i_data (r3_side),
        .o_data (x_side)
    );

    assign {x_ok, x_tid, x_e0, x_e1, x_e2, x_ein} = x_side;

    // stage 4 and 5: share, first and last index
    logic             n4_lt;
    logic [IDX_W-1:0] n4_work;
    logic             r4_vld, r4_ok;
    logic [IDX_W-1:0] r4_work, r4_prod;
    logic [WKC_W-1:0] r4_add;
    logic [EXT_W-1:0] r4_e0, r4_e1, r4_e2, r4_ein;
    logic             r5_vld, r5_ok;
    logic [IDX_W-1:0] r5_work, r5_begin, r5_last, r5_rnum;
    logic [EXT_W-1:0] r5_e0, r5_e1, r5_e2, r5_ein;

    always_comb begin
        n4_lt   = {1'b0, x_tid} < x_spill;
        n4_work = n4_lt ? x_base + IDX_W'(1) : x_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            r4_vld <= x_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_ok    <= x_ok;
        r4_work  <= n4_work;
        r4_prod  <= IDX_W'(IDX_W'(x_tid) * n4_work);
        r4_add   <= n4_lt ? '0 : x_spill;
        r4_e0    <= x_e0;
        r4_e1    <= x_e1;
        r4_e2    <= x_e2;
        r4_ein   <= x_ein;
        r5_ok    <= r4_ok;
        r5_work  <= r4_work;
        r5_begin <= r4_prod + IDX_W'(r4_add);
        r5_last  <= r4_prod + IDX_W'(r4_add) + r4_work - IDX_W'(1);
        r5_rnum  <= r4_work + IDX_W'(r4_ein) - IDX_W'(1);
        r5_e0    <= r4_e0;
        r5_e1    <= r4_e1;
        r5_e2    <= r4_e2;
        r5_ein   <= r4_ein;
    end

    // innermost unravel and rows touched
    logic             y_vld;
    logic [IDX_W-1:0] y_qa, y_qb, y_qr;
    logic [EXT_W-1:0] y_ra, y_rb;
    logic [SY_W-1:0]  y_side;
    logic             y_ok;
    logic [IDX_W-1:0] y_work;
    logic [OIDX_W-1:0] y_begin, y_last;
    logic [EXT_W-1:0] y_e0, y_e1;

    wpc_div #(.N(IDX_W), .D(EXT_W), .K(EDIV_STEPS)) u_ydiv_begin (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r5_vld),
        .i_dividend  (r5_begin),
        .i_divisor   (r5_e2),
        .o_valid     (y_vld),
        .o_quotient  (y_qa),
        .o_remainder (y_ra)
    );

    wpc_div #(.N(IDX_W), .D(EXT_W), .K(EDIV_STEPS)) u_ydiv_last (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r5_vld),
        .i_dividend  (r5_last),
        .i_divisor   (r5_e2),
        .o_valid     (),
        .o_quotient  (y_qb),
        .o_remainder (y_rb)
    );

    wpc_div #(.N(IDX_W), .D(EXT_W), .K(EDIV_STEPS)) u_ydiv_rows (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r5_vld),
        .i_dividend  (r5_rnum),
        .i_divisor   (r5_ein),
        .o_valid     (),
        .o_quotient  (y_qr),
        .o_remainder ()
    );

    wpc_delay #(.W(SY_W), .L(EDIV_LAT)) u_ydly (
        .i_clk  (i_clk),
        .i_data ({r5_ok, r5_work, r5_begin[OIDX_W-1:0], r5_last[OIDX_W-1:0], r5_e0, r5_e1}),
        .o_data (y_side)
    );

    assign {y_ok, y_work, y_begin, y_last, y_e0, y_e1} = y_side;

    // middle unravel
    logic             z_vld;
    logic [IDX_W-1:0] z_qa, z_qb, z_qr, z_work;
    logic [EXT_W-1:0] z_ra1, z_rb1, z_ra2, z_rb2, z_e0;
    logic [SZ_W-1:0]  z_side;
    logic             z_ok;
    logic [OIDX_W-1:0] z_begin, z_last;

    wpc_div #(.N(IDX_W), .D(EXT_W), .K(EDIV_STEPS)) u_zdiv_begin (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (y_vld),
        .i_dividend  (y_qa),
        .i_divisor   (y_e1),
        .o_valid     (z_vld),
        .o_quotient  (z_qa),
        .o_remainder (z_ra1)
    );

    wpc_div #(.N(IDX_W), .D(EXT_W), .K(EDIV_STEPS)) u_zdiv_last (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (y_vld),
        .i_dividend  (y_qb),
        .i_divisor   (y_e1),
        .o_valid     (),
        .o_quotient  (z_qb),
        .o_remainder (z_rb1)
    );

    wpc_delay #(.W(SZ_W), .L(EDIV_LAT)) u_zdly (
        .i_clk  (i_clk),
        .i_data ({y_ok, y_work, y_begin, y_last, y_e0, y_ra, y_rb, y_qr}),
        .o_data (z_side)
    );

    assign {z_ok, z_work, z_begin, z_last, z_e0, z_ra2, z_rb2, z_qr} = z_side;

    // output register
    logic               n_nz;
    logic [COORD_W-1:0] n_bc0, n_ec0;
    logic               r_out_vld, r_id_valid;
    logic [OIDX_W-1:0]  r_first, r_last;
    logic [IDX_W-1:0]   r_share, r_rows;
    logic [COORD_W-1:0] r_bc0, r_bc1, r_bc2, r_ec0, r_ec1, r_ec2;

    always_comb begin
        n_nz  = (z_work != '0);
        n_bc0 = (z_qa == IDX_W'(z_e0)) ? '0 : z_qa[COORD_W-1:0];
        n_ec0 = (z_qb == IDX_W'(z_e0)) ? '0 : z_qb[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= z_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id_valid <= z_ok;
        r_first    <= z_ok ? z_begin : '0;
        r_last     <= (z_ok && n_nz) ? z_last : '0;
        r_share    <= z_ok ? z_work : '0;
        r_rows     <= (z_ok && n_nz) ? z_qr : '0;
        r_bc0      <= z_ok ? n_bc0 : '0;
        r_bc1      <= z_ok ? z_ra1[COORD_W-1:0] : '0;
        r_bc2      <= z_ok ? z_ra2[COORD_W-1:0] : '0;
        r_ec0      <= (z_ok && n_nz) ? n_ec0 : '0;
        r_ec1      <= (z_ok && n_nz) ? z_rb1[COORD_W-1:0] : '0;
        r_ec2      <= (z_ok && n_nz) ? z_rb2[COORD_W-1:0] : '0;
    end

    assign o_strobe        = r_out_vld;
    assign o_id_valid      = r_id_valid;
    assign o_first_index   = r_first;
    assign o_last_index    = r_last;
    assign o_share_count   = r_share;
    assign o_rows_touched  = r_rows;
    assign o_begin_coord_0 = r_bc0;
    assign o_begin_coord_1 = r_bc1;
    assign o_begin_coord_2 = r_bc2;
    assign o_end_coord_0   = r_ec0;
    assign o_end_coord_1   = r_ec1;
    assign o_end_coord_2   = r_ec2;

    `WPC_ASSERT_NEXT(a_rst_clears, i_clk, !i_rst_n, !o_strobe)
    `WPC_ASSERT_IMPLY(a_bad_id_zero, i_clk, i_rst_n, o_strobe && !o_id_valid,
        o_share_count == '0 && o_first_index == '0 && o_rows_touched == '0)
    `WPC_ASSERT_IMPLY(a_empty_share, i_clk, i_rst_n, o_strobe && o_share_count == '0,
        o_last_index == '0 && o_rows_touched == '0 && o_end_coord_0 == '0)
    `WPC_ASSERT_IMPLY(a_span_order, i_clk, i_rst_n, o_strobe && o_share_count != '0,
        o_last_index >= o_first_index && o_rows_touched != '0)
endmodule
`default_nettype wire

// File: sim/wpc_checker.sv
// Checker for the work partition coordinates block: predicts each query's share
// from its own copy of the configuration and compares every strobed result.
// Depends on wpc_pkg.
module wpc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [wpc_pkg::WK_W-1:0]          i_worker_id,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready,
    input  logic [wpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wpc_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                              o_strobe,
    input  logic                              o_id_valid,
    input  logic [wpc_pkg::OIDX_W-1:0]        o_first_index,
    input  logic [wpc_pkg::OIDX_W-1:0]        o_last_index,
    input  logic [wpc_pkg::IDX_W-1:0]         o_share_count,
    input  logic [wpc_pkg::IDX_W-1:0]         o_rows_touched,
    input  logic [wpc_pkg::COORD_W-1:0]       o_begin_coord_0,
    input  logic [wpc_pkg::COORD_W-1:0]       o_begin_coord_1,
    input  logic [wpc_pkg::COORD_W-1:0]       o_begin_coord_2,
    input  logic [wpc_pkg::COORD_W-1:0]       o_end_coord_0,
    input  logic [wpc_pkg::COORD_W-1:0]       o_end_coord_1,
    input  logic [wpc_pkg::COORD_W-1:0]       o_end_coord_2,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import wpc_pkg::*;

    typedef struct packed {
        logic               id_valid;
        logic [OIDX_W-1:0]  first_index;
        logic [OIDX_W-1:0]  last_index;
        logic [IDX_W-1:0]   share_count;
        logic [IDX_W-1:0]   rows_touched;
        logic [COORD_W-1:0] bc0, bc1, bc2, ec0, ec1, ec2;
    } t_share;

    logic [DIM_W-1:0] dims_q;
    logic [EXT_W-1:0] ext_q [MAX_DIMS];
    logic [WKC_W-1:0] workers_q;
    t_share           share_q [$];

    assign o_pending = share_q.size();

    function automatic logic [63:0] ext_of(input logic [EXT_W-1:0] e);
        if (e == 0) return 1;
        if (e > 4096) return 4096;
        return e;
    endfunction

    function automatic t_share predict_share(input logic [WK_W-1:0] wid);
        t_share      s;
        logic [63:0] ex [3];
        logic [63:0] wt [3];
        logic [63:0] cb [3];
        logic [63:0] ce [3];
        logic [63:0] total, base, spill, work, first, last, acc, rows;
        int          nd;
        s = '0;
        if (wid >= workers_q) return s;
        nd = (dims_q == 0) ? 1 : dims_q;
        total = 1;
        for (int d = 0; d < 3; d++) begin
            ex[d] = (d < nd) ? ext_of(ext_q[d]) : 1;
            total = total * ex[d];
        end
        acc = 1;
        for (int d = 2; d >= 0; d--) begin
            wt[d] = acc;
            acc = acc * ex[d];
        end
        base  = total / workers_q;
        spill = total % workers_q;
        if (wid < spill) begin
            work  = base + 1;
            first = wid * work;
        end else begin
            work  = base;
            first = wid * work + spill;
        end
        last = 0;
        rows = 0;
        for (int d = 0; d < 3; d++) begin
            cb[d] = (d < nd) ? (first / wt[d]) % ex[d] : 0;
            ce[d] = 0;
        end
        if (work != 0) begin
            last = first + work - 1;
            for (int d = 0; d < nd; d++) ce[d] = (last / wt[d]) % ex[d];
            rows = (work + ex[nd-1] - 1) / ex[nd-1];
        end
        s.id_valid     = 1'b1;
        s.first_index  = first[OIDX_W-1:0];
        s.last_index   = last[OIDX_W-1:0];
        s.share_count  = work[IDX_W-1:0];
        s.rows_touched = rows[IDX_W-1:0];
        s.bc0 = cb[0][COORD_W-1:0]; s.bc1 = cb[1][COORD_W-1:0]; s.bc2 = cb[2][COORD_W-1:0];
        s.ec0 = ce[0][COORD_W-1:0]; s.ec1 = ce[1][COORD_W-1:0]; s.ec2 = ce[2][COORD_W-1:0];
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t checker: %s got %0d want %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_share got, want;
        if (!i_rst_n) begin
            dims_q    = RST_DIM_COUNT;
            for (int d = 0; d < MAX_DIMS; d++) ext_q[d] = RST_EXTENT;
            workers_q = RST_WORKER_COUNT;
            share_q.delete();
        end else begin
            if (o_strobe) begin
                got = {o_id_valid, o_first_index, o_last_index, o_share_count,
                       o_rows_touched, o_begin_coord_0, o_begin_coord_1,
                       o_begin_coord_2, o_end_coord_0, o_end_coord_1, o_end_coord_2};
                if (share_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    want = share_q.pop_front();
                    if (got.id_valid != want.id_valid)
                        report_mismatch("id_valid", got.id_valid, want.id_valid);
                    if (got.first_index != want.first_index)
                        report_mismatch("first_index", got.first_index, want.first_index);
                    if (got.last_index != want.last_index)
                        report_mismatch("last_index", got.last_index, want.last_index);
                    if (got.share_count != want.share_count)
                        report_mismatch("share_count", got.share_count, want.share_count);
                    if (got.rows_touched != want.rows_touched)
                        report_mismatch("rows_touched", got.rows_touched, want.rows_touched);
                    if (got.bc0 != want.bc0) report_mismatch("begin_coord_0", got.bc0, want.bc0);
                    if (got.bc1 != want.bc1) report_mismatch("begin_coord_1", got.bc1, want.bc1);
                    if (got.bc2 != want.bc2) report_mismatch("begin_coord_2", got.bc2, want.bc2);
                    if (got.ec0 != want.ec0) report_mismatch("end_coord_0", got.ec0, want.ec0);
                    if (got.ec1 != want.ec1) report_mismatch("end_coord_1", got.ec1, want.ec1);
                    if (got.ec2 != want.ec2) report_mismatch("end_coord_2", got.ec2, want.ec2);
                end
            end
            if (start && !busy) share_q.push_back(predict_share(i_worker_id));
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DIM_COUNT:    dims_q = i_cfg_data[DIM_W-1:0];
                    CFG_EXTENT_0:     ext_q[0] = i_cfg_data;
                    CFG_EXTENT_1:     ext_q[1] = i_cfg_data;
                    CFG_EXTENT_2:     ext_q[2] = i_cfg_data;
                    CFG_WORKER_COUNT: workers_q = i_cfg_data[WKC_W-1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: sim/tb_top.sv
// Top of the work partition coordinates testbench: drives queries and register
// writes through several configurations; the checker predicts and compares.
// Depends on wpc_pkg, work_partition_coordinates and wpc_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wpc_pkg::*;

    localparam int LATENCY = 40;

    logic                 i_clk, i_rst_n, start, busy;
    logic [WK_W-1:0]      i_worker_id;
    logic                 i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 o_strobe, o_id_valid;
    logic [OIDX_W-1:0]    o_first_index, o_last_index;
    logic [IDX_W-1:0]     o_share_count, o_rows_touched;
    logic [COORD_W-1:0]   o_begin_coord_0, o_begin_coord_1, o_begin_coord_2;
    logic [COORD_W-1:0]   o_end_coord_0, o_end_coord_1, o_end_coord_2;
    int                   fail_count, pending;
    bit                   calm;

    work_partition_coordinates i_dut (.*);
    wpc_checker i_chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic send_query(input int wid);
        while (!calm && $urandom_range(99) < 31) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_worker_id <= WK_W'(wid);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        while ($urandom_range(99) < 31) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DAT_W'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_layout(input int nd, input int e0, input int e1, input int e2,
                              input int wk);
        drain();
        write_reg(CFG_DIM_COUNT, nd);
        write_reg(CFG_EXTENT_0, e0);
        write_reg(CFG_EXTENT_1, e1);
        write_reg(CFG_EXTENT_2, e2);
        write_reg(CFG_WORKER_COUNT, wk);
        write_reg(3'd5 + 3'($urandom_range(2)), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int rand_extent();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 4096;
            2:       return $urandom_range(8191);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    initial begin
        start = 1'b0; i_worker_id = '0; i_cfg_valid = 1'b0;
        i_cfg_index = '0; i_cfg_data = '0; calm = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int w = 0; w < 5; w++) send_query(w);
        send_query(63);
        set_layout(3, 4096, 4096, 4096, 64);
        send_query(0); send_query(63); send_query(31);
        set_layout(0, 8191, 0, 5, 0);
        send_query(0); send_query(1);
        set_layout(1, 5, 7, 7, 64);
        send_query(0); send_query(4); send_query(5); send_query(63);
        set_layout(2, 0, 4097, 3, 127);
        send_query(0); send_query(42); send_query(63);
        set_layout(2, 3, 5, 9, 1);
        send_query(0); send_query(1);

        for (int ph = 0; ph < 40; ph++) begin
            set_layout($urandom_range(3), rand_extent(), rand_extent(), rand_extent(),
                       ($urandom_range(3) == 0) ? $urandom_range(127)
                                                : $urandom_range(1, 64));
            calm = (ph % 8 == 3);
            for (int k = 0; k < 28; k++) begin
                if ($urandom_range(3) == 0) send_query($urandom_range(63));
                else send_query($urandom_range(i_chk.workers_q > 0 ?
                                               i_chk.workers_q - 1 : 0));
                if (k == 14 && ph == 5) drain();
            end
        end
        calm = 1'b0;
        drain();
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
